@@ rtl/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfa_pkg: shared constants for the bitmap frame allocator
// Default geometry, field widths, command and status codes.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // default geometry
    localparam int FRAME_COUNT_DEF = 256;
    localparam int BATCH_SIZE_DEF  = 20;
    localparam int PAGE_BYTES_DEF  = 4096;

    // fixed field widths
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;

    // used map is kept as words of this many frame bits
    localparam int WORD_W = 32;
    localparam int BIT_W  = $clog2(WORD_W);

    // heap base after reset
    localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 32'h0010_0000;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // request function codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // classified command codes passed from front to back
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RANGE = 2'd2;

endpackage

@@ rtl/bfa_if.sv @@
// ----------------------------------------------------------------------------
// bfa_if: channel interfaces of the bitmap frame allocator
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------

// request channel: allocate or free
interface bfa_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] free_address;

    modport source (output valid, func, free_address, input ready);
    modport sink   (input valid, func, free_address, output ready);
endinterface

// response channel: one word per request
interface bfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_address;
    logic [1:0]  status;

    modport source (output valid, frame_address, status, input ready);
    modport sink   (input valid, frame_address, status, output ready);
endinterface

// configuration channel: heap base write
interface bfa_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] heap_base;

    modport source (output valid, heap_base, input ready);
    modport sink   (input valid, heap_base, output ready);
endinterface

@@ rtl/bfa_ram.sv @@
// ----------------------------------------------------------------------------
// bfa_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bfa_queue.sv @@
// ----------------------------------------------------------------------------
// bfa_queue: two-entry command queue
// Decouples request classification from command execution.
// ----------------------------------------------------------------------------
module bfa_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign push_ok = i_push && (r_cnt != 2'd2);
    assign pop_ok  = i_pop && (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // hold entries
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/bfa_front.sv @@
// ----------------------------------------------------------------------------
// bfa_front: request classifier
// Accepts requests, range-checks free addresses and turns them into
// frame indices, and pushes one command per request into the queue.
// ----------------------------------------------------------------------------
module bfa_front
    import bfa_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
    bfa_req_if.sink                         i_req,
    input  logic [ADDR_W-1:0]               i_heap_base,
    input  logic                            i_q_full,
    input  logic                            i_busy,
    output logic                            o_push,
    output logic [OP_W+$clog2(FRAME_COUNT)-1:0] o_cmd
);

    localparam int FW         = $clog2(FRAME_COUNT);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int UW         = ADDR_W - PAGE_SHIFT;

    logic [ADDR_W:0]   diff;
    logic [UW-1:0]     page;
    logic              out_of_heap;
    logic [OP_W-1:0]   op;

    // offset into the heap, borrow marks an address below the base
    assign diff        = {1'b0, i_req.free_address} - {1'b0, i_heap_base};
    assign page        = diff[ADDR_W-1:PAGE_SHIFT];
    assign out_of_heap = diff[ADDR_W] || (ADDR_W'(page) >= ADDR_W'(FRAME_COUNT));

    // classify the word
    always_comb begin
        if (i_req.func == FUNC_ALLOC) begin
            op = OP_ALLOC;
        end else if (out_of_heap) begin
            op = OP_RANGE;
        end else begin
            op = OP_FREE;
        end
    end

    assign i_req.ready = !i_q_full && !i_busy;
    assign o_push      = i_req.valid && !i_q_full && !i_busy;
    assign o_cmd       = {op, page[FW-1:0]};

endmodule

@@ rtl/bfa_back.sv @@
// ----------------------------------------------------------------------------
// bfa_back: command executor
// Owns the used map, the prefetched batch and the response register.
// Refills the batch by scanning map words for the lowest free frame.
// ----------------------------------------------------------------------------
module bfa_back
    import bfa_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int BATCH_SIZE  = BATCH_SIZE_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [ADDR_W-1:0]               i_heap_base,
    input  logic                            i_cmd_valid,
    input  logic [OP_W+$clog2(FRAME_COUNT)-1:0] i_cmd,
    output logic                            o_pop,
    output logic                            o_busy,
    bfa_rsp_if.source                       o_rsp
);

    localparam int FW         = $clog2(FRAME_COUNT);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int WORDS      = (FRAME_COUNT + WORD_W - 1) / WORD_W;
    localparam int WAW        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LAST_BITS  = FRAME_COUNT - (WORDS - 1) * WORD_W;
    localparam int PW         = $clog2(BATCH_SIZE + 1);
    localparam int BIW        = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;

    // bits past the last frame read as used
    localparam logic [WORD_W:0]   LOW_ONES =
        (WORD_W + 1)'(((WORD_W + 1)'(1) << LAST_BITS) - (WORD_W + 1)'(1));
    localparam logic [WORD_W-1:0] PAD_MASK = ~LOW_ONES[WORD_W-1:0];

    // sequencer states
    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_ALLOC     = 3'd2;
    localparam logic [2:0] S_FILL_LOAD = 3'd3;
    localparam logic [2:0] S_FILL_SCAN = 3'd4;
    localparam logic [2:0] S_FREE_LOAD = 3'd5;
    localparam logic [2:0] S_EMIT      = 3'd6;

    // control registers
    logic [2:0]          r_state,    n_state;
    logic [WAW-1:0]      r_clr_addr, n_clr_addr;
    logic [PW-1:0]       r_pos,      n_pos;
    logic [PW-1:0]       r_fill_cnt, n_fill_cnt;
    logic                r_refill,   n_refill;
    logic                r_out_valid, n_out_valid;

    // payload registers
    logic [WAW-1:0]      r_word_addr, n_word_addr;
    logic [WORD_W-1:0]   r_word,      n_word;
    logic [FW-1:0]       r_free_frame, n_free_frame;
    logic [ADDR_W-1:0]   r_res_addr,  n_res_addr;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [ADDR_W-1:0]   r_out_addr,  n_out_addr;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [FW-1:0]       r_batch [BATCH_SIZE];

    // map memory ports
    logic                ram_we;
    logic [WAW-1:0]      ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WAW-1:0]      ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    // batch write port
    logic                batch_we;
    logic [BIW-1:0]      batch_wi;
    logic [FW-1:0]       batch_wd;

    // command fields and derived values
    logic [OP_W-1:0]     cmd_op;
    logic [FW-1:0]       cmd_frame;
    logic [FW+BIT_W-1:0] cmd_ext;
    logic [FW+BIT_W-1:0] free_ext;
    logic [BIT_W-1:0]    zero_bit;
    logic                zero_found;
    logic [WAW+BIT_W-1:0] claim_full;
    logic [FW-1:0]       claim_idx;
    logic [FW-1:0]       alloc_idx;
    logic                out_load;

    assign cmd_op     = i_cmd[OP_W+FW-1:FW];
    assign cmd_frame  = i_cmd[FW-1:0];
    assign cmd_ext    = {{BIT_W{1'b0}}, cmd_frame};
    assign free_ext   = {{BIT_W{1'b0}}, r_free_frame};
    assign claim_full = {r_word_addr, zero_bit};
    assign claim_idx  = claim_full[FW-1:0];
    assign alloc_idx  = r_batch[r_pos[BIW-1:0]];

    // lowest clear bit of the held map word
    always_comb begin
        zero_bit   = '0;
        zero_found = 1'b0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!r_word[b]) begin
                zero_bit   = BIT_W'(b);
                zero_found = 1'b1;
            end
        end
    end

    assign out_load = (r_state == S_EMIT) && (!r_out_valid || o_rsp.ready);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_pos        = r_pos;
        n_fill_cnt   = r_fill_cnt;
        n_refill     = r_refill;
        n_word_addr  = r_word_addr;
        n_word       = r_word;
        n_free_frame = r_free_frame;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        o_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_word_addr;
        ram_wdata    = r_word;
        ram_raddr    = r_word_addr;
        batch_we     = 1'b0;
        batch_wi     = r_fill_cnt[BIW-1:0];
        batch_wd     = claim_idx;

        unique case (r_state)
            S_CLEAR: begin
                // sweep the map to all free
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + WAW'(1);
                if (r_clr_addr == WAW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    unique case (cmd_op)
                        OP_ALLOC: begin
                            if (r_refill || (r_pos == PW'(BATCH_SIZE))) begin
                                n_refill    = 1'b1;
                                n_word_addr = '0;
                                ram_raddr   = '0;
                                n_fill_cnt  = '0;
                                n_state     = S_FILL_LOAD;
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                        OP_FREE: begin
                            n_free_frame = cmd_frame;
                            ram_raddr    = cmd_ext[WAW+BIT_W-1:BIT_W];
                            n_state      = S_FREE_LOAD;
                        end
                        default: begin
                            n_res_addr   = '0;
                            n_res_status = ST_RANGE;
                            n_state      = S_EMIT;
                        end
                    endcase
                end
            end
            S_FILL_LOAD: begin
                // take the map word, padding marked used
                n_word = ram_rdata |
                    ((r_word_addr == WAW'(WORDS - 1)) ? PAD_MASK : '0);
                n_state = S_FILL_SCAN;
            end
            S_FILL_SCAN: begin
                if (zero_found) begin
                    // claim the lowest free frame
                    batch_we = 1'b1;
                    n_word   = r_word | (WORD_W'(1) << zero_bit);
                    if (r_fill_cnt == PW'(BATCH_SIZE - 1)) begin
                        ram_we    = 1'b1;
                        ram_wdata = r_word | (WORD_W'(1) << zero_bit);
                        n_refill  = 1'b0;
                        n_pos     = '0;
                        n_state   = S_ALLOC;
                    end else begin
                        n_fill_cnt = r_fill_cnt + PW'(1);
                    end
                end else begin
                    // word exhausted: write it back, then move to the next word or report full
                    ram_we = 1'b1;
                    if (r_word_addr == WAW'(WORDS - 1)) begin
                        n_res_addr   = '0;
                        n_res_status = ST_FULL;
                        n_state      = S_EMIT;
                    end else begin
                        n_word_addr = r_word_addr + WAW'(1);
                        ram_raddr   = r_word_addr + WAW'(1);
                        n_state     = S_FILL_LOAD;
                    end
                end
            end
            S_ALLOC: begin
                // hand out the next batch entry
                n_res_addr   = i_heap_base +
                    (ADDR_W'(alloc_idx) << PAGE_SHIFT);
                n_res_status = ST_OK;
                n_pos        = r_pos + PW'(1);
                n_state      = S_EMIT;
            end
            S_FREE_LOAD: begin
                // clear the frame bit
                ram_we       = 1'b1;
                ram_waddr    = free_ext[WAW+BIT_W-1:BIT_W];
                ram_wdata    = ram_rdata & ~(WORD_W'(1) << free_ext[BIT_W-1:0]);
                n_res_addr   = '0;
                n_res_status = ST_OK;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // response register
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        if (out_load) begin
            n_out_valid  = 1'b1;
            n_out_addr   = r_res_addr;
            n_out_status = r_res_status;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_pos       <= '0;
            r_fill_cnt  <= '0;
            r_refill    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_pos       <= n_pos;
            r_fill_cnt  <= n_fill_cnt;
            r_refill    <= n_refill;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_word_addr  <= n_word_addr;
        r_word       <= n_word;
        r_free_frame <= n_free_frame;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
        if (batch_we) begin
            r_batch[batch_wi] <= batch_wd;
        end
    end

    bfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_busy              = (r_state == S_CLEAR);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.frame_address = r_out_addr;
    assign o_rsp.status        = r_out_status;

    // batch position never passes the batch end
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(BATCH_SIZE))
        else $error("batch position past batch end");

    // commands are taken only when the sequencer is idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("command popped while busy");

    // a failed request never carries an address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_OK)) |-> (r_out_addr == '0))
        else $error("failure response with non-zero address");

    // a batch entry is served only once the batch is complete
    a_alloc_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |-> (!r_refill && (r_pos != PW'(BATCH_SIZE))))
        else $error("allocation from an incomplete batch");

    // a response is loaded only from the emit state
    a_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid)) |-> ($past(r_state) == S_EMIT))
        else $error("response loaded outside emit");

endmodule

@@ rtl/bitmap_frame_allocator.sv @@
// Alloc is served from the prefetched batch. When the batch is used up it is
// refilled first, one frame claimed per cycle within a 32-frame map word,
// each word read from the map RAM before it is scanned.
// Concurrency: one request in flight in the executor; a two-entry queue ahead.
// Reset: map cleared by a pass over its words, requests held off.
// ----------------------------------------------------------------------------
// bitmap_frame_allocator: physical page-frame allocator
// Front classifier, command queue and executor over a one-bit-per-frame map.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int BATCH_SIZE  = BATCH_SIZE_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfa_req_if.sink    i_req,
    bfa_rsp_if.source  o_rsp,
    bfa_cfg_if.sink    i_cfg
);

    localparam int CW = OP_W + $clog2(FRAME_COUNT);

    logic [ADDR_W-1:0] r_heap_base;
    logic              q_push;
    logic [CW-1:0]     q_in;
    logic              q_full;
    logic              q_pop;
    logic [CW-1:0]     q_out;
    logic              q_empty;
    logic              busy;

    // heap base register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= HEAP_BASE_RST;
        end else if (i_cfg.valid) begin
            r_heap_base <= i_cfg.heap_base;
        end
    end

    bfa_front #(
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_front (
        .i_req       (i_req),
        .i_heap_base (r_heap_base),
        .i_q_full    (q_full),
        .i_busy      (busy),
        .o_push      (q_push),
        .o_cmd       (q_in)
    );

    bfa_queue #(
        .WIDTH (CW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    bfa_back #(
        .FRAME_COUNT (FRAME_COUNT),
        .BATCH_SIZE  (BATCH_SIZE),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_heap_base (r_heap_base),
        .i_cmd_valid (!q_empty),
        .i_cmd       (q_out),
        .o_pop       (q_pop),
        .o_busy      (busy),
        .o_rsp       (o_rsp)
    );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bitmap frame allocator
// Allocate and free requests go in through the request channel. A frame map
// model predicts each response word, and the response channel is checked
// against it in order. Heap base changes between phases, while the block is
// idle. Both sides idle at random, and there is a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import bfa_pkg::*;

    localparam int FRAMES   = FRAME_COUNT_DEF;
    localparam int BATCH    = BATCH_SIZE_DEF;
    localparam int PAGE     = PAGE_BYTES_DEF;
    localparam int PHASES   = 8;
    localparam int PHASE_N  = 125;
    localparam int IDLE_MAX = 18;
    localparam int HOLD_LEN = 150;
    localparam int SETTLE   = 8;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [ADDR_W-1:0]   frame_address;
        logic [STATUS_W-1:0] status;
    } t_frame_reply;

    // frame map model: used bits, prefetched batch and the replies it owes
    class frame_map_model;
        logic [ADDR_W-1:0] heap_base;
        bit [FRAMES-1:0]   used_map;
        int                batch_idx [BATCH];
        int                batch_pos;
        bit                refill;
        int                handed_out [$];
        t_frame_reply      owed [$];
        int                errors;

        function new();
            heap_base = HEAP_BASE_RST;
            used_map  = '0;
            batch_pos = 0;
            refill    = 1'b1;
            errors    = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // work out the reply that an accepted request will produce
        function void note_request(logic func, logic [ADDR_W-1:0] addr);
            t_frame_reply      r;
            logic [ADDR_W-1:0] frame;
            int                found;
            int                slot;
            r.frame_address = '0;
            r.status        = ST_OK;
            if (func == FUNC_ALLOC) begin
                if (batch_pos >= BATCH) refill = 1'b1;
                if (refill) begin
                    slot = 0;
                    // claim the lowest free frame for each slot of the batch
                    while (slot < BATCH && r.status == ST_OK) begin
                        found = -1;
                        for (int f = 0; f < FRAMES && found < 0; f++) begin
                            if (!used_map[f]) found = f;
                        end
                        if (found < 0) begin
                            r.status = ST_FULL;
                        end else begin
                            used_map[found] = 1'b1;
                            batch_idx[slot] = found;
                            slot++;
                        end
                    end
                    if (r.status == ST_OK) begin
                        batch_pos = 0;
                        refill    = 1'b0;
                    end
                end
                if (r.status == ST_OK) begin
                    r.frame_address = heap_base + 32'(batch_idx[batch_pos] * PAGE);
                    handed_out.push_back(batch_idx[batch_pos]);
                    batch_pos++;
                end
            end else if (addr < heap_base) begin
                r.status = ST_RANGE;
            end else begin
                frame = (addr - heap_base) / PAGE;
                if (frame >= FRAMES) r.status = ST_RANGE;
                else used_map[frame[7:0]] = 1'b0;
            end
            owed.push_back(r);
        endfunction

        task report(string msg);
            if (errors < 40) $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        // compare a response word with the oldest owed reply
        task check_result(logic [ADDR_W-1:0] addr, logic [STATUS_W-1:0] status);
            t_frame_reply r;
            if (owed.size() == 0) begin
                report($sformatf("response %h/%0d with nothing owed", addr, status));
            end else begin
                r = owed.pop_front();
                if (addr !== r.frame_address)
                    report($sformatf("frame_address %h, want %h", addr, r.frame_address));
                if (status !== r.status)
                    report($sformatf("status %0d, want %0d", status, r.status));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bfa_req_if req_ch ();
    bfa_rsp_if rsp_ch ();
    bfa_cfg_if cfg_ch ();

    frame_map_model model = new();

    bit tx_idle;
    bit rx_idle;
    int hold_len = 0;
    int stall_cycles = 0;

    bitmap_frame_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // offer one request word, with an optional gap ahead of it
    task automatic send_request(logic func, logic [ADDR_W-1:0] addr);
        int gap;
        gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.func         <= func;
        req_ch.free_address <= addr;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        model.note_request(func, addr);
    endtask

    // drop the request valid and wait until every owed reply is back
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (model.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_heap_base(logic [ADDR_W-1:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.heap_base <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        model.heap_base = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // receiver: random gaps ahead of each word, one long hold-off on request
    initial begin
        int gap;
        bit hold_taken;
        rsp_ch.ready <= 1'b0;
        hold_taken = 1'b0;
        forever begin
            gap = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
            if (hold_len > 0 && !hold_taken) begin
                gap        = hold_len;
                hold_taken = 1'b1;
            end
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
        end
    end

    // check every accepted response word
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            model.check_result(rsp_ch.frame_address, rsp_ch.status);
    end

    // watchdog: give up after a long stretch with no word moving anywhere
    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int                pct;
        int                pick;
        int                idx;
        logic              func;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] base;
        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.func         <= FUNC_ALLOC;
        req_ch.free_address <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.heap_base    <= '0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: first fill, frees of every kind, then a wrapping base
        base = HEAP_BASE_RST;
        send_request(FUNC_ALLOC, 32'hFFFF_FFFF);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_FREE, base + PAGE + PAGE - 1);        // unaligned
        send_request(FUNC_FREE, base + PAGE);                   // already free
        send_request(FUNC_FREE, base - 1);                      // below heap
        send_request(FUNC_FREE, 32'h0);
        send_request(FUNC_FREE, base + FRAMES * PAGE);          // beyond heap
        send_request(FUNC_FREE, base + FRAMES * PAGE - 1);      // last frame
        send_request(FUNC_FREE, base + 5 * PAGE);               // still in batch
        settle();
        write_heap_base(32'hFFFF_F000);
        base = 32'hFFFF_F000;
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_ALLOC, 32'h0);                        // address wraps
        send_request(FUNC_FREE, base + 2 * PAGE);               // wrapped, below
        send_request(FUNC_FREE, 32'hFFFF_FFFF);

        // random phases: new base, new mix of allocate and free, new idling
        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: base = 32'h0;
                1: base = $urandom() & 32'hFFFF_F000;
                2: base = 32'hFFFF_F000;
                3: base = $urandom();
                4: base = 32'hFFFF_FFFF;
                5: base = HEAP_BASE_RST;
                6: base = $urandom() & 32'hFFFF_F000;
                default: base = 32'h7FFF_F000;
            endcase
            write_heap_base(base);
            tx_idle = (p % 4 == 0) || (p % 4 == 2);
            rx_idle = (p % 4 == 0) || (p % 4 == 3);
            pct = (p % 2 == 0) ? 95 - 2 * p : 60 - 10 * p / 2;
            for (int n = 0; n < PHASE_N; n++) begin
                if (p == 1 && n == 30) hold_len = HOLD_LEN;
                if (p == 3 && n == 60) settle();
                if ($urandom_range(0, 99) < pct) begin
                    func = FUNC_ALLOC;
                    addr = $urandom();
                end else begin
                    func = FUNC_FREE;
                    pick = $urandom_range(0, 9);
                    if (pick < 5 && model.handed_out.size() > 0) begin
                        // free a frame that was handed out, at any offset
                        idx  = $urandom_range(0, model.handed_out.size() - 1);
                        addr = base + 32'(model.handed_out[idx] * PAGE)
                               + $urandom_range(0, PAGE - 1);
                        model.handed_out.delete(idx);
                    end else if (pick < 8) begin
                        addr = base + $urandom_range(0, FRAMES * PAGE - 1);
                    end else if (pick == 8) begin
                        if ($urandom_range(0, 1))
                            addr = base - 1 - $urandom_range(0, 65535);
                        else
                            addr = base + FRAMES * PAGE + $urandom_range(0, 65535);
                    end else begin
                        addr = $urandom();
                    end
                end
                send_request(func, addr);
            end
        end

        settle();
        if (model.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
